// ===== design/cwsc_pkg.sv =====
`default_nettype none
package cwsc_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int DIV_W      = 56;
  localparam int DSR_W      = 48;
  localparam int ROOT_W     = 28;
  localparam int SPEED_W    = 48;
  localparam int COEF_W     = 32;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_SPACING = 3'd6;

  // Gain computer constants
  localparam logic [SPEED_W-1:0] SPEED_RESET = 48'd256000;
  localparam logic [SPEED_W-1:0] SPEED_MIN   = 48'd256;
  localparam logic [COEF_W-1:0]  COEF_ONE    = 32'd1073741824;

  // Limiter and clipper constants, Q.23
  localparam logic signed [35:0] LIMIT_HI = 36'sd33554432;
  localparam logic signed [35:0] LIMIT_LO = -36'sd33554432;
  localparam logic signed [27:0] K_OFF    = 28'sd5920854;
  localparam logic signed [24:0] K_MUL    = 25'sd2188712;
  localparam logic signed [27:0] K_BIAS   = 28'sd2090204;
  localparam logic signed [24:0] K_KEEP   = 25'sd6199895;
  localparam logic signed [27:0] K_KNEE   = 28'sd8011058;

  localparam logic [16:0] WET_ONE = 17'd65536;

  // Datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE,
    OP_DIV_VARY,
    OP_TAKE_VARY,
    OP_SQRT,
    OP_DIV_COEF,
    OP_TAKE_COEF,
    OP_DIV_REC1,
    OP_TAKE_REC1,
    OP_DIV_REC2,
    OP_TAKE_REC2,
    OP_DIV_SPEED,
    OP_TAKE_SPEED,
    OP_SQUARE,
    OP_SCALE,
    OP_MAKEUP,
    OP_CLIP_POS_TRACK,
    OP_CLIP_POS,
    OP_CLIP_NEG_TRACK,
    OP_CLIP_NEG,
    OP_MIX_WET,
    OP_MIX_DRY,
    OP_MIX_OUT
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic above;
    logic div_done;
    logic sqrt_done;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== design/cwsc_div.sv =====
`default_nettype none
module cwsc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cwsc_pkg::DIV_W-1:0] dividend,
  input  logic [cwsc_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [cwsc_pkg::DIV_W-1:0] quotient
);
  import cwsc_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W:0]   rem_sh;
  logic             qbit;
  logic [DSR_W-1:0] rem_nxt;

  // Restoring step: one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    qbit    = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = qbit ? DSR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_W-2:0], qbit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== design/cwsc_sqrt.sv =====
`default_nettype none
module cwsc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [2*cwsc_pkg::ROOT_W-1:0] value,
  output logic                        done,
  output logic [cwsc_pkg::ROOT_W-1:0] root
);
  import cwsc_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [4:0]            cnt_r;
  logic [2*ROOT_W-1:0]   val_r;
  logic [ROOT_W+1:0]     rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_W+3:0]     rem_sh;
  logic [ROOT_W+3:0]     trial;
  logic                  take;

  // Digit-by-digit root: two radicand bits per cycle
  always_comb begin
    rem_sh = {rem_r, val_r[2*ROOT_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        val_r  <= value;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        val_r  <= {val_r[2*ROOT_W-3:0], 2'b00};
        rem_r  <= take ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
        root_r <= {root_r[ROOT_W-2:0], take};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== design/cwsc_dp.sv =====
`default_nettype none
module cwsc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cwsc_pkg::dp_op_t                op,
  output cwsc_pkg::dp_status_t            status,
  input  logic [cwsc_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            cfg_we,
  input  logic [cwsc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cwsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [cwsc_pkg::SAMPLE_W-1:0]   out_sample
);
  import cwsc_pkg::*;

  // Configuration registers
  logic [23:0] threshold_r;
  logic [23:0] pre_gain_r;
  logic [31:0] attack_r;
  logic [33:0] release_r;
  logic [23:0] makeup_r;
  logic [16:0] wet_r;

  // Gain computer state
  logic [SPEED_W-1:0] speed_even_r, speed_odd_r;
  logic [COEF_W-1:0]  coef_even_r, coef_odd_r;
  logic               phase_r;

  // Clipper state
  logic signed [27:0] cl_r;
  logic               pos_r, neg_r;

  // Per-item working registers
  logic signed [23:0]        dry_r;
  logic signed [32:0]        x_r;
  logic [SPEED_W-1:0]        s_r;
  logic [COEF_W-1:0]         c_r;
  logic [30:0]               tgt_r;
  logic signed [33:0]        t_r;
  logic [33:0]               c2_r;
  logic                      qneg_r;
  logic signed [45:0]        p1_r;
  logic signed [41:0]        p2_r;
  logic [SAMPLE_W-1:0]       out_r;

  // Shared units
  logic              div_start, sqrt_start;
  logic [DIV_W-1:0]  div_dvd, div_q;
  logic [DSR_W-1:0]  div_dsr;
  logic              div_neg;
  logic              div_done, sqrt_done;
  logic [ROOT_W-1:0] att;

  cwsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  cwsc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value ({s_r, 8'd0}),
    .done  (sqrt_done),
    .root  (att)
  );

  // Constant multiply with truncation toward zero, Q.23
  function automatic logic signed [27:0] kmul(input logic signed [27:0] a,
                                               input logic signed [24:0] k);
    logic signed [52:0] p;
    p = a * k;
    if (p < 0) p = p + 53'sd8388607;
    return p[50:23];
  endfunction

  logic [27:0]        mag;
  logic               above;
  logic signed [33:0] diff, dec, sel_num;
  logic [33:0]        num_abs;
  logic [33:0]        rate;
  logic signed [34:0] qmag, qs, csum;
  logic [COEF_W-1:0]  c_clamp;
  logic [29:0]        vary;
  logic [30:0]        thr30;
  logic [48:0]        n49;
  logic [SPEED_W-1:0] n_sat, n_cap, n_fin;
  logic [35:0]        cap4;
  logic signed [48:0] pre_p, pre_adj;
  logic [63:0]        sq;
  logic signed [62:0] sc_p, sc_adj;
  logic signed [57:0] mk_p, mk_adj;
  logic signed [35:0] mk_q;
  logic signed [32:0] mk_lim;
  logic signed [27:0] x28;
  logic               cmp_pos, cmp_neg;
  logic signed [27:0] km_a, km_y;
  logic signed [24:0] km_k;
  logic [16:0]        wet_eff;
  logic signed [46:0] mix_sum, mix_adj;
  logic signed [30:0] mix_q;
  logic [SAMPLE_W-1:0] mix_sat;

  always_comb begin
    // Detector magnitude and threshold compare
    mag   = x_r[32] ? 28'(-x_r) : x_r[27:0];
    above = (mag > {4'd0, threshold_r});

    // Signed numerators for the coefficient divisions
    diff    = $signed({3'd0, tgt_r}) - $signed({2'd0, c_r});
    dec     = $signed({2'd0, COEF_ONE}) - $signed({2'd0, c_r});
    rate    = above ? release_r : {2'd0, attack_r};
    sel_num = (op == OP_DIV_COEF) ? diff : (op == OP_DIV_REC1) ? dec : t_r;
    num_abs = sel_num[33] ? 34'(-sel_num) : sel_num;

    // Divider operand select
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = s_r;
    div_neg   = 1'b0;
    case (op)
      OP_DIV_VARY: begin
        div_start = 1'b1;
        div_dvd   = {2'd0, threshold_r, 30'd0};
        div_dsr   = {20'd0, mag};
      end
      OP_DIV_COEF: begin
        div_start = 1'b1;
        div_dvd   = {14'd0, num_abs, 8'd0};
        div_dsr   = {20'd0, att};
        div_neg   = sel_num[33];
      end
      OP_DIV_REC1, OP_DIV_REC2: begin
        div_start = 1'b1;
        div_dvd   = {14'd0, num_abs, 8'd0};
        div_neg   = sel_num[33];
      end
      OP_DIV_SPEED: begin
        div_start = 1'b1;
        div_dvd   = {14'd0, rate, 8'd0};
      end
      default: ;
    endcase
    sqrt_start = (op == OP_SQRT);

    // Signed quotient and coefficient clamp
    qmag    = $signed({1'b0, div_q[33:0]});
    qs      = qneg_r ? -qmag : qmag;
    csum    = $signed({3'd0, c_r}) + qs;
    c_clamp = csum[34] ? '0 : (csum[33:32] != 2'd0) ? '1 : csum[31:0];

    // Target gain
    vary  = div_q[29:0];
    thr30 = {threshold_r, 7'd0};

    // Speed step with ceiling, release cap and floor
    n49   = {1'b0, s_r} - {1'b0, SPEED_MIN} + {7'd0, div_q[41:0]};
    n_sat = n49[48] ? '1 : n49[47:0];
    cap4  = {release_r, 2'b00};
    n_cap = (above && (n_sat > {12'd0, cap4})) ? {12'd0, cap4} : n_sat;
    n_fin = (n_cap < SPEED_MIN) ? SPEED_MIN : n_cap;

    // Pre-gain, truncated toward zero
    pre_p   = dry_r * $signed({1'b0, pre_gain_r});
    pre_adj = pre_p + (pre_p[48] ? 49'sd1048575 : 49'sd0);

    // Squared coefficient and scaling
    sq     = c_r * c_r;
    sc_p   = $signed(x_r[27:0]) * $signed({1'b0, c2_r});
    sc_adj = sc_p + (sc_p[62] ? 63'sd1073741823 : 63'sd0);

    // Makeup gain and limiter
    mk_p   = x_r * $signed({1'b0, makeup_r});
    mk_adj = mk_p + (mk_p[57] ? 58'sd4194303 : 58'sd0);
    mk_q   = mk_adj[57:22];
    if (mk_q > LIMIT_HI) mk_lim = 33'(LIMIT_HI);
    else if (mk_q < LIMIT_LO) mk_lim = 33'(LIMIT_LO);
    else mk_lim = mk_q[32:0];

    // Clipper multiplier operand select
    x28     = x_r[27:0];
    cmp_pos = (x28 < cl_r);
    cmp_neg = (x28 > cl_r);
    km_a    = cl_r;
    km_k    = K_MUL;
    case (op)
      OP_CLIP_POS_TRACK: begin
        km_a = cmp_pos ? x28 : cl_r;
        km_k = cmp_pos ? K_MUL : K_KEEP;
      end
      OP_CLIP_NEG_TRACK: begin
        km_a = cmp_neg ? x28 : cl_r;
        km_k = cmp_neg ? K_MUL : K_KEEP;
      end
      default: ;
    endcase
    km_y = kmul(km_a, km_k);

    // Dry/wet blend, truncated toward zero and saturated
    wet_eff = (wet_r > WET_ONE) ? WET_ONE : wet_r;
    mix_sum = 47'(p1_r) + 47'(p2_r);
    mix_adj = mix_sum + (mix_sum[46] ? 47'sd65535 : 47'sd0);
    mix_q   = mix_adj[46:16];
    if (mix_q > 31'sd8388607) mix_sat = 24'h7FFFFF;
    else if (mix_q < -31'sd8388608) mix_sat = 24'h800000;
    else mix_sat = mix_q[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= 24'd8388608;
      pre_gain_r   <= 24'd1048576;
      attack_r     <= 32'd2560;
      release_r    <= 34'd5120;
      makeup_r     <= 24'd4194304;
      wet_r        <= WET_ONE;
      speed_even_r <= SPEED_RESET;
      speed_odd_r  <= SPEED_RESET;
      coef_even_r  <= COEF_ONE;
      coef_odd_r   <= COEF_ONE;
      phase_r      <= 1'b0;
      cl_r         <= '0;
      pos_r        <= 1'b0;
      neg_r        <= 1'b0;
    end else begin
      // Register writes; clip spacing has no bearing on the output
      if (cfg_we) begin
        case (cfg_idx)
          REG_THRESHOLD:    threshold_r <= cfg_wdata[23:0];
          REG_PRE_GAIN:     pre_gain_r  <= cfg_wdata[23:0];
          REG_ATTACK_RATE:  attack_r    <= cfg_wdata[31:0];
          REG_RELEASE_RATE: release_r   <= cfg_wdata;
          REG_MAKEUP_GAIN:  makeup_r    <= cfg_wdata[23:0];
          REG_WET_MIX:      wet_r       <= cfg_wdata[16:0];
          default: ;
        endcase
      end

      if (div_start) qneg_r <= div_neg;

      case (op)
        OP_LOAD: begin
          dry_r <= $signed(in_sample);
          s_r   <= phase_r ? ((speed_even_r < SPEED_MIN) ? SPEED_MIN : speed_even_r)
                           : ((speed_odd_r < SPEED_MIN) ? SPEED_MIN : speed_odd_r);
          c_r   <= phase_r ? coef_even_r : coef_odd_r;
        end
        OP_PRE:       x_r   <= 33'($signed(pre_adj[48:20]));
        OP_TAKE_VARY: tgt_r <= ({1'b0, vary} < thr30) ? thr30 : {1'b0, vary};
        OP_TAKE_COEF, OP_TAKE_REC2: c_r <= c_clamp;
        OP_TAKE_REC1: t_r   <= qs[33:0];
        OP_TAKE_SPEED: begin
          // Write back the pair used by this item and hand over to the other
          s_r <= n_fin;
          if (phase_r) begin
            speed_even_r <= n_fin;
            coef_even_r  <= c_r;
          end else begin
            speed_odd_r <= n_fin;
            coef_odd_r  <= c_r;
          end
          phase_r <= ~phase_r;
        end
        OP_SQUARE: c2_r <= sq[63:30];
        OP_SCALE:  x_r  <= sc_adj[62:30];
        OP_MAKEUP: x_r  <= mk_lim;
        OP_CLIP_POS_TRACK: begin
          if (pos_r) cl_r <= (cmp_pos ? K_OFF : K_BIAS) + km_y;
        end
        OP_CLIP_POS: begin
          pos_r <= (x28 > K_KNEE);
          if (x28 > K_KNEE) x_r <= 33'(K_OFF + km_y);
        end
        OP_CLIP_NEG_TRACK: begin
          if (neg_r) cl_r <= (cmp_neg ? -K_OFF : -K_BIAS) + km_y;
        end
        OP_CLIP_NEG: begin
          neg_r <= (x28 < -K_KNEE);
          if (x28 < -K_KNEE) x_r <= 33'(-K_OFF + km_y);
        end
        OP_MIX_WET: begin
          // Clipper output is one item late: blend the held value, keep the new one
          p1_r <= cl_r * $signed({1'b0, wet_eff});
          cl_r <= x28;
        end
        OP_MIX_DRY: p2_r  <= dry_r * $signed({1'b0, 17'(WET_ONE - wet_eff)});
        OP_MIX_OUT: out_r <= mix_sat;
        default: ;
      endcase
    end
  end

  assign status.above     = above;
  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;
  assign out_sample       = out_r;

endmodule
`default_nettype wire

// ===== design/cwsc_ctrl.sv =====
`default_nettype none
module cwsc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  cwsc_pkg::dp_status_t status,
  output cwsc_pkg::dp_op_t     op
);
  import cwsc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_CHK,
    S_V_WAIT, S_SQ_GO, S_SQ_WAIT, S_CA_GO, S_CA_WAIT,
    S_R1_WAIT, S_R2_GO, S_R2_WAIT,
    S_SP_GO, S_SP_WAIT,
    S_SQUARE, S_SCALE, S_MAKEUP,
    S_CP1, S_CP2, S_CP3, S_CP4,
    S_MX1, S_MX2, S_MX3
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequence the datapath
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        op        = OP_LOAD;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        op        = OP_PRE;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (status.above) begin
          op        = OP_DIV_VARY;
          state_nxt = S_V_WAIT;
        end else begin
          op        = OP_DIV_REC1;
          state_nxt = S_R1_WAIT;
        end
      end
      S_V_WAIT: if (status.div_done) begin
        op        = OP_TAKE_VARY;
        state_nxt = S_SQ_GO;
      end
      S_SQ_GO: begin
        op        = OP_SQRT;
        state_nxt = S_SQ_WAIT;
      end
      S_SQ_WAIT: if (status.sqrt_done) begin
        state_nxt = S_CA_GO;
      end
      S_CA_GO: begin
        op        = OP_DIV_COEF;
        state_nxt = S_CA_WAIT;
      end
      S_CA_WAIT: if (status.div_done) begin
        op        = OP_TAKE_COEF;
        state_nxt = S_SP_GO;
      end
      S_R1_WAIT: if (status.div_done) begin
        op        = OP_TAKE_REC1;
        state_nxt = S_R2_GO;
      end
      S_R2_GO: begin
        op        = OP_DIV_REC2;
        state_nxt = S_R2_WAIT;
      end
      S_R2_WAIT: if (status.div_done) begin
        op        = OP_TAKE_REC2;
        state_nxt = S_SP_GO;
      end
      S_SP_GO: begin
        op        = OP_DIV_SPEED;
        state_nxt = S_SP_WAIT;
      end
      S_SP_WAIT: if (status.div_done) begin
        op        = OP_TAKE_SPEED;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        op        = OP_SQUARE;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        op        = OP_SCALE;
        state_nxt = S_MAKEUP;
      end
      S_MAKEUP: begin
        op        = OP_MAKEUP;
        state_nxt = S_CP1;
      end
      S_CP1: begin
        op        = OP_CLIP_POS_TRACK;
        state_nxt = S_CP2;
      end
      S_CP2: begin
        op        = OP_CLIP_POS;
        state_nxt = S_CP3;
      end
      S_CP3: begin
        op        = OP_CLIP_NEG_TRACK;
        state_nxt = S_CP4;
      end
      S_CP4: begin
        op        = OP_CLIP_NEG;
        state_nxt = S_MX1;
      end
      S_MX1: begin
        op        = OP_MIX_WET;
        state_nxt = S_MX2;
      end
      S_MX2: begin
        op        = OP_MIX_DRY;
        state_nxt = S_MX3;
      end
      S_MX3: if (!out_valid_r || out_tready) begin
        op        = OP_MIX_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold a finished item until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_MIX_OUT) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_no_unit_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !status.div_done && !status.sqrt_done)
    else $error("arithmetic unit finished while controller idle");

  a_valid_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_MX3)
    else $error("output valid raised outside final blend");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MX3 && out_valid_r && !out_tready |=> state_r == S_MX3)
    else $error("pending item overwritten");

endmodule
`default_nettype wire

// ===== design/compressor_with_soft_clip.sv =====
`default_nettype none
// Mono compressor with soft clipper. One sample enters per item on the in_
// stream and one processed sample leaves on the out_ stream, one item at a
// time. The gain computer runs three divisions on one shared radix-2 divider
// and, above threshold, a square root unit. The next item can be accepted in
// the cycle the result turns valid. A finished item sits in an output
// register, so the next item is accepted while it waits; only the final step
// of the following item stalls until the earlier result is taken. The
// clipper output lags the input by one item. cfg_ready is high only while
// the block is idle; a write in the cycle an item is accepted already
// applies to that item.
// clip_spacing is accepted but does not change the output.
module compressor_with_soft_clip (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] sample_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [33:0] cfg_data
);
  import cwsc_pkg::*;

  dp_op_t     op;
  dp_status_t status;
  logic       cfg_we;

  cwsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .op         (op)
  );

  cwsc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .status     (status),
    .in_sample  (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_sample (out_tdata)
  );

  // Take register writes only while no item is in flight
  assign cfg_ready = in_tready;
  assign cfg_we    = cfg_valid && cfg_ready;

endmodule
`default_nettype wire

// ===== tb/sv/tb_compressor_with_soft_clip.sv =====
`default_nettype none
module tb_compressor_with_soft_clip;
  import cwsc_pkg::*;

  // Index past the last register, expected to be ignored
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // [23:0] sample_in
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [23:0] sample_out
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [33:0] cfg_data;

  compressor_with_soft_clip uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of registers and state
  logic [23:0] thr_r, pre_r, mk_r;
  logic [31:0] atk_r;
  logic [33:0] rel_r;
  logic [16:0] wet_r;
  logic [4:0]  spc_r;
  longint unsigned spd_even, spd_odd;
  longint          cf_even, cf_odd;
  bit              use_even, pos_clip, neg_clip;
  longint          clip_prev;

  // Expected output samples, tagged with a known value where one exists
  logic [23:0] exp_samples[$];
  bit          exp_known[$];
  logic [23:0] exp_fixed[$];

  int errors, checked, n_items, idle_mode;
  bit timed_out;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clamp_cf(longint c);
    if (c < 0) return 0;
    if (c > 64'sd4294967295) return 64'sd4294967295;
    return c;
  endfunction

  function automatic longint unsigned next_speed(longint unsigned s, longint unsigned rate);
    longint unsigned n;
    n = s - 256 + (rate << 8) / s;
    if (n > 64'd281474976710655) n = 64'd281474976710655;
    return n;
  endfunction

  // Advance the gain computer for one pair
  function automatic void update_gain(longint mag, inout longint unsigned s, inout longint c);
    longint vary, thr30, tgt, att, d, t;
    longint unsigned thr;
    thr = thr_r;
    if (s < 256) s = 256;
    if (s > 64'd281474976710655) s = 64'd281474976710655;
    if (mag > longint'(thr)) begin
      vary = longint'((thr << 30) / longint'(mag));
      thr30 = longint'(thr << 7);
      tgt = (vary < thr30) ? thr30 : vary;
      att = longint'(isqrt(s << 8));
      c = clamp_cf(c + ((tgt - c) * 256) / att);
      s = next_speed(s, rel_r);
      if (s > 4 * longint'(rel_r)) s = 4 * longint'(rel_r);
      if (s < 256) s = 256;
    end else begin
      d = 64'sd1073741824 - c;
      t = (d * 256) / longint'(s);
      t = (t * 256) / longint'(s);
      c = clamp_cf(c + t);
      s = next_speed(s, atk_r);
      if (s < 256) s = 256;
    end
  endfunction

  // Compute the processed sample for one input sample
  function automatic logic [23:0] process_sample(logic [23:0] smp);
    longint dry, x, mag, c, proc, res, wet;
    longint unsigned c2;
    dry = longint'($signed(smp));
    x = (dry * longint'(pre_r)) / (64'sd1 << 20);
    mag = x < 0 ? -x : x;
    if (use_even) begin update_gain(mag, spd_even, cf_even); c = cf_even; end
    else begin update_gain(mag, spd_odd, cf_odd); c = cf_odd; end
    c2 = (longint'(c) * longint'(c)) >> 30;
    x = (x * longint'(c2)) / 64'sd1073741824;
    x = (x * longint'(mk_r)) / (64'sd1 << 22);
    use_even = !use_even;
    if (x > 64'sd33554432) x = 64'sd33554432;
    if (x < -64'sd33554432) x = -64'sd33554432;
    if (pos_clip) begin
      if (x < clip_prev) clip_prev = 5920854 + (x * 2188712) / (64'sd1 << 23);
      else clip_prev = 2090204 + (clip_prev * 6199895) / (64'sd1 << 23);
    end
    pos_clip = 0;
    if (x > 8011058) begin
      pos_clip = 1; x = 5920854 + (clip_prev * 2188712) / (64'sd1 << 23);
    end
    if (neg_clip) begin
      if (x > clip_prev) clip_prev = -5920854 + (x * 2188712) / (64'sd1 << 23);
      else clip_prev = -2090204 + (clip_prev * 6199895) / (64'sd1 << 23);
    end
    neg_clip = 0;
    if (x < -8011058) begin
      neg_clip = 1; x = -5920854 + (clip_prev * 2188712) / (64'sd1 << 23);
    end
    // the delay tap holds the new value for every spacing: one sample latency
    proc = clip_prev;
    clip_prev = x;
    wet = (wet_r > 17'd65536) ? 65536 : longint'(wet_r);
    if (wet == 65536) res = proc;
    else res = (proc * wet + dry * (65536 - wet)) / 65536;
    if (res > 8388607) res = 8388607;
    if (res < -8388608) res = -8388608;
    return res[23:0];
  endfunction

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (exp_samples.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [33:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD:    thr_r = val[23:0];
      REG_PRE_GAIN:     pre_r = val[23:0];
      REG_ATTACK_RATE:  atk_r = val[31:0];
      REG_RELEASE_RATE: rel_r = val;
      REG_MAKEUP_GAIN:  mk_r = val[23:0];
      REG_WET_MIX:      wet_r = val[16:0];
      REG_CLIP_SPACING: spc_r = val[4:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic [23:0] smp, bit known, logic [23:0] fixed);
    int gap_pct;
    gap_pct = (idle_mode == 3) ? 6 : 58;
    while (idle_mode[0] && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
    exp_samples.push_back(process_sample(smp));
    exp_known.push_back(known);
    exp_fixed.push_back(fixed);
    n_items++;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (idle_mode[1])
      out_tready <= ($urandom_range(99) >= ((idle_mode == 3) ? 6 : 58));
    else out_tready <= 1'b1;
  end

  // Compare each accepted output sample with the oldest expectation
  always @(posedge clk) begin
    logic [23:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output sample %0d", $signed(out_tdata));
      end else begin
        want = exp_samples.pop_front();
        if (exp_known.pop_front() && exp_fixed[0] != want) begin
          errors++;
          if (errors <= 10) $display("table row disagrees: table %0d predicted %0d",
                                     $signed(exp_fixed[0]), $signed(want));
        end
        void'(exp_fixed.pop_front());
        if (out_tdata !== want) begin
          errors++;
          if (errors <= 10) $display("sample_out mismatch: expected %0d actual %0d",
                                     $signed(want), $signed(out_tdata));
        end
        checked++;
      end
    end
  end

  // Directed rows: sample, known flag, known result
  typedef struct { logic [23:0] smp; bit known; logic [23:0] res; } row_t;
  row_t dir_rows[12];

  initial begin
    int ph;
    dir_rows[0]  = '{24'h000000, 1'b1, 24'h000000};
    dir_rows[1]  = '{24'h7FFFFF, 1'b1, 24'h000000};
    dir_rows[2]  = '{24'h800000, 1'b0, 24'h0};
    dir_rows[3]  = '{24'h7FFFFF, 1'b0, 24'h0};
    dir_rows[4]  = '{24'h7FFFFF, 1'b0, 24'h0};
    dir_rows[5]  = '{24'h000001, 1'b0, 24'h0};
    dir_rows[6]  = '{24'h800000, 1'b0, 24'h0};
    dir_rows[7]  = '{24'h800000, 1'b0, 24'h0};
    dir_rows[8]  = '{24'hFFFFFF, 1'b0, 24'h0};
    dir_rows[9]  = '{24'h400000, 1'b0, 24'h0};
    dir_rows[10] = '{24'hC00000, 1'b0, 24'h0};
    dir_rows[11] = '{24'h000000, 1'b0, 24'h0};
    errors = 0; checked = 0; n_items = 0; idle_mode = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    thr_r = 24'd8388608; pre_r = 24'd1048576; atk_r = 32'd2560; rel_r = 34'd5120;
    mk_r = 24'd4194304; wet_r = 17'd65536; spc_r = 5'd1;
    spd_even = 256000; spd_odd = 256000;
    cf_even = 64'sd1073741824; cf_odd = 64'sd1073741824;
    use_even = 0; pos_clip = 0; neg_clip = 0; clip_prev = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings: first output is the empty clipper
    foreach (dir_rows[i]) send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].res);
    wait_idle();
    // Extremes of every register
    write_reg(REG_THRESHOLD, 34'd838861);
    write_reg(REG_PRE_GAIN, 34'd10485760);
    write_reg(REG_ATTACK_RATE, 34'hFFFFFFFF);
    write_reg(REG_RELEASE_RATE, 34'h3FFFFFFFF);
    write_reg(REG_MAKEUP_GAIN, 34'hFFFFFF);
    write_reg(REG_WET_MIX, 34'h1FFFF);
    write_reg(REG_CLIP_SPACING, 34'd31);
    for (int i = 0; i < 8; i++) send_sample(24'($urandom), 1'b0, '0);
    wait_idle();
    write_reg(REG_ATTACK_RATE, 34'd1);
    write_reg(REG_RELEASE_RATE, 34'd1);
    write_reg(REG_MAKEUP_GAIN, 34'd0);
    write_reg(REG_WET_MIX, 34'd0);
    write_reg(REG_CLIP_SPACING, 34'd0);
    write_reg(REG_UNUSED, 34'h123456);
    for (int i = 0; i < 5; i++) send_sample(24'($urandom), 1'b0, '0);
    wait_idle();

    // Random phases with new settings; idle mode cycles through all four
    for (ph = 0; ph < 12; ph++) begin
      idle_mode = ph % 4;
      write_reg(REG_THRESHOLD, 34'($urandom_range(8388608, 838861)));
      write_reg(REG_PRE_GAIN, 34'($urandom_range(10485760, 1048576)));
      write_reg(REG_ATTACK_RATE, 34'((ph % 3 == 0) ? $urandom : $urandom_range(20000, 1)));
      write_reg(REG_RELEASE_RATE, (ph % 3 == 1) ? 34'({$urandom, $urandom})
                                                : 34'($urandom_range(40000, 1)));
      write_reg(REG_MAKEUP_GAIN,
                34'((ph % 2) ? $urandom : $urandom_range(8388608, 2097152)));
      write_reg(REG_WET_MIX, 34'((ph % 3 == 2) ? $urandom_range(65536) : 65536));
      write_reg(REG_CLIP_SPACING, 34'($urandom_range(16, 1)));
      for (int i = 0; i < 125; i++) begin
        logic [23:0] v;
        case ($urandom_range(3))
          0: v = 24'($urandom);
          1: v = 24'($urandom_range(2097152) - 1048576);
          2: v = $urandom_range(1) ? 24'(24'h7FFFFF - $urandom_range(255))
                                   : 24'(24'h800000 + $urandom_range(255));
          default: v = (n_items % 40 < 20) ? 24'($urandom_range(8388607, 4194304))
                                           : 24'($urandom_range(65535));
        endcase
        send_sample(v, 1'b0, '0);
      end
      wait_idle();
    end

    $display("%0d samples sent, %0d outputs checked over 12 random settings and four idle modes",
             n_items, checked);
    if (errors == 0 && exp_samples.size() == 0) $display("tb_compressor_with_soft_clip passed");
    else begin
      $display("%0d mismatches, %0d outputs missing", errors, exp_samples.size());
      $display("tb_compressor_with_soft_clip failed");
    end
    $finish;
  end

  // Timeout guard
  initial begin
    #20000000;
    $display("timeout");
    $display("tb_compressor_with_soft_clip failed");
    $finish;
  end

endmodule
`default_nettype wire
